FILE: sv/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Implication checks on the rising clock edge with an active-low reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: sv/ssv_pkg.sv
// ------------------------------------------------------------------------
// ssv_pkg
// Types and constants shared by the sensor stream validator modules.
// ------------------------------------------------------------------------
`default_nettype none
package ssv_pkg;
	localparam int AXES = 3;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALE     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT = 8'd3;

	localparam logic [31:0] TIMEOUT_RST   = 32'd20000;
	localparam logic [15:0] STALE_RST     = 16'd100;
	localparam logic [15:0] WINDOW_RST    = 16'd100;
	localparam logic [31:0] ERR_LIMIT_RST = 32'd10000;

	localparam logic KIND_QUERY = 1'b1;

	localparam int FLAG_NO_DATA = 0;
	localparam int FLAG_TIMEOUT = 1;
	localparam int FLAG_STALE   = 2;
	localparam int FLAG_ERRORS  = 3;
	localparam int FLAG_DENSITY = 4;

	typedef struct packed {
		logic              kind;
		logic [63:0]       time_us;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
		logic [31:0]       sensor_errors;
		logic [7:0]        sensor_priority;
	} in_item_t;

	typedef struct packed {
		logic [15:0] confidence_q15;
		logic [4:0]  error_flags;
		logic [7:0]  priority_out;
		logic [31:0] rms_x;
		logic [31:0] rms_y;
		logic [31:0] rms_z;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;
endpackage
`default_nettype wire

FILE: sv/ssv_div.sv
// ------------------------------------------------------------------------
// ssv_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ------------------------------------------------------------------------
`default_nettype none
module ssv_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [63:0]       dividend,
	input  wire logic [31:0]       divisor,
	output ssv_pkg::unit_sts_t     sts,
	output logic [63:0]            quotient
);
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;

	always_comb begin
		trial = {rem_q, quo_q[63]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: sv/ssv_sqrt.sv
// ------------------------------------------------------------------------
// ssv_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ------------------------------------------------------------------------
`default_nettype none
module ssv_sqrt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [63:0]   radicand,
	output ssv_pkg::unit_sts_t sts,
	output logic [31:0]        root
);
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;
	logic        ge;

	always_comb begin
		trial = res_q + bit_q;
		ge    = v_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The trial bit walks down two places a step, from bit 62 to bit 0.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (ge) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = res_q[31:0];
endmodule
`default_nettype wire

FILE: sv/sensor_stream_validator_core.sv
// A query whose critical check fails skips the divider; a first sample skips
// the per-axis work. One item is in work at a time; the next is accepted in
// the cycle after the result is loaded. Per axis the serial divider runs
// twice, before and after the shift-add multiplier, then the square-root unit.
// Reset clears the control and tracking state and loads the register
// defaults; payload and multiplier registers are not reset. No clearing pass.
`default_nettype none
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// sensor_stream_validator_core
// Tracks sample timing, repeats, error density and per-axis rms deviation,
// and answers confidence queries with a sticky error mask.
// ------------------------------------------------------------------------
module sensor_stream_validator_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire ssv_pkg::in_item_t                item,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output ssv_pkg::out_item_t                    result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ssv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                      cfg_data
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_S0    = 4'd1;
	localparam logic [3:0] ST_AX0   = 4'd2;
	localparam logic [3:0] ST_DIVM  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_ACC   = 4'd5;
	localparam logic [3:0] ST_DIVR  = 4'd6;
	localparam logic [3:0] ST_SQ    = 4'd7;
	localparam logic [3:0] ST_AXEND = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_Q0    = 4'd10;
	localparam logic [3:0] ST_QDIV  = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	localparam int MUL_BITS = 36;
	localparam logic signed [17:0] LP_KEEP  = 18'sd64881;
	localparam logic signed [11:0] LP_TAKE  = 12'sd655;
	localparam logic signed [49:0] LP_ROUND = 50'sd32768;
	localparam logic signed [35:0] MEAN_MAX = 36'sd2147483647;
	localparam logic signed [35:0] MEAN_MIN = -36'sd2147483648;

	logic [3:0]  state_q;
	logic [1:0]  ax_q;
	logic [5:0]  mul_cnt_q;

	logic [31:0] timeout_q;
	logic [15:0] stale_q;
	logic [15:0] window_q;
	logic [31:0] err_limit_q;

	logic        has_data_q;
	logic [63:0] last_time_q;
	logic [31:0] sample_count_q;
	logic [31:0] last_errors_q;
	logic [15:0] density_q;
	logic [31:0] equal_run_q;
	logic [7:0]  priority_q;
	logic [4:0]  mask_q;
	logic [15:0] conf_q;
	logic signed [31:0] prev_q [3];
	logic signed [31:0] lowpass_q [3];
	logic signed [31:0] mean_q [3];
	logic [63:0] m2_q [3];
	logic [31:0] rms_q [3];

	ssv_pkg::in_item_t  item_q;
	ssv_pkg::out_item_t result_q;
	logic               result_valid_q;

	logic signed [33:0] d_q;
	logic signed [34:0] delta_q;
	logic signed [49:0] lp_mul_q;
	logic [34:0]        a_q;
	logic [35:0]        b_q;
	logic [71:0]        acc_q;

	// Datapath nets.
	logic signed [31:0] item_v [3];
	logic signed [31:0] cur_v, cur_lp, cur_mean, cur_prev;
	logic [63:0]        cur_m2;
	logic signed [33:0] d_w;
	logic signed [34:0] delta_w;
	logic [34:0]        delta_mag_w;
	logic signed [49:0] lp_mul_w;
	logic signed [35:0] q_w, qs_w, m_w, dm_w;
	logic signed [31:0] mean_sat_w;
	logic [35:0]        b_mag_w;
	logic [63:0]        prod_sat_w;
	logic [64:0]        m2_sum_w;
	logic [63:0]        m2_new_w;
	logic [31:0]        rms_div_w;
	logic signed [43:0] lp_add_w;
	logic signed [49:0] lp_sum_w;
	logic [31:0]        err_rise_w;
	logic [32:0]        dens_sum_w;
	logic [15:0]        dens_new_w;
	logic [63:0]        elapsed_w;
	logic               timed_out_w, stale_w, err_over_w, q_crit_w;
	logic [15:0]        win_w;
	logic [15:0]        dens_cap_w;
	logic [16:0]        conf_w;
	logic               out_free_w;
	ssv_pkg::out_item_t out_w;

	logic               div_start;
	logic [63:0]        div_dividend;
	logic [31:0]        div_divisor;
	logic [63:0]        div_quo;
	ssv_pkg::unit_sts_t div_sts;
	logic               sq_start;
	logic [31:0]        sq_root;
	ssv_pkg::unit_sts_t sq_sts;

	ssv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	ssv_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_quo),
		.sts      (sq_sts),
		.root     (sq_root)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free_w   = !result_valid_q || !result_stall;

	always_comb begin
		item_v[0] = item_q.value_x;
		item_v[1] = item_q.value_y;
		item_v[2] = item_q.value_z;
		cur_v    = item_v[ax_q];
		cur_lp   = lowpass_q[ax_q];
		cur_mean = mean_q[ax_q];
		cur_prev = prev_q[ax_q];
		cur_m2   = m2_q[ax_q];

		// Deviation from the low-pass and from the running mean.
		d_w         = {{2{cur_v[31]}}, cur_v} - {{2{cur_lp[31]}}, cur_lp};
		delta_w     = {d_w[33], d_w} - {{3{cur_mean[31]}}, cur_mean};
		delta_mag_w = delta_w[34] ? 35'(-delta_w) : 35'(delta_w);
		lp_mul_w    = cur_lp * LP_KEEP;

		// Quotient is truncated toward zero, then the mean saturates.
		q_w  = {1'b0, div_quo[34:0]};
		qs_w = delta_q[34] ? -q_w : q_w;
		m_w  = {{4{cur_mean[31]}}, cur_mean} + qs_w;
		if (m_w > MEAN_MAX) begin
			mean_sat_w = 32'sh7FFF_FFFF;
		end else if (m_w < MEAN_MIN) begin
			mean_sat_w = 32'sh8000_0000;
		end else begin
			mean_sat_w = m_w[31:0];
		end
		dm_w    = {{2{d_q[33]}}, d_q} - {{4{mean_sat_w[31]}}, mean_sat_w};
		b_mag_w = dm_w[35] ? 36'(-dm_w) : 36'(dm_w);

		prod_sat_w = (|acc_q[71:64]) ? '1 : acc_q[63:0];
		m2_sum_w   = {1'b0, cur_m2} + {1'b0, prod_sat_w};
		m2_new_w   = m2_sum_w[64] ? '1 : m2_sum_w[63:0];
		rms_div_w  = (sample_count_q > 32'd1) ? sample_count_q - 32'd1 : 32'd1;

		lp_add_w = cur_v * LP_TAKE;
		lp_sum_w = lp_mul_q + {{6{lp_add_w[43]}}, lp_add_w} + LP_ROUND;

		err_rise_w = item_q.sensor_errors - last_errors_q;
		dens_sum_w = {17'b0, density_q} + {1'b0, err_rise_w};
		if (item_q.sensor_errors > last_errors_q) begin
			dens_new_w = (dens_sum_w > 33'd65535) ? 16'hFFFF : dens_sum_w[15:0];
		end else begin
			dens_new_w = (density_q != 16'd0) ? density_q - 16'd1 : 16'd0;
		end

		elapsed_w   = item_q.time_us - last_time_q;
		timed_out_w = elapsed_w > {32'b0, timeout_q};
		stale_w     = equal_run_q > {16'b0, stale_q};
		err_over_w  = last_errors_q > err_limit_q;
		q_crit_w    = !has_data_q || timed_out_w || stale_w || err_over_w;
		win_w       = (window_q == 16'd0) ? 16'd1 : window_q;
		dens_cap_w  = (density_q > win_w) ? win_w : density_q;
		conf_w      = 17'd32768 - div_quo[16:0];

		div_start    = 1'b0;
		div_dividend = {29'b0, delta_mag_w};
		div_divisor  = sample_count_q;
		unique case (state_q)
			ST_AX0: begin
				div_start = 1'b1;
			end
			ST_ACC: begin
				div_start    = 1'b1;
				div_dividend = m2_new_w;
				div_divisor  = rms_div_w;
			end
			ST_Q0: begin
				div_start    = !q_crit_w;
				div_dividend = {33'b0, dens_cap_w, 15'b0};
				div_divisor  = {16'b0, win_w};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
		sq_start = (state_q == ST_DIVR) && div_sts.done;

		out_w.confidence_q15 = conf_q;
		out_w.error_flags    = mask_q;
		out_w.priority_out   = priority_q;
		out_w.rms_x          = (0 < ssv_pkg::AXES) ? rms_q[0] : 32'd0;
		out_w.rms_y          = (1 < ssv_pkg::AXES) ? rms_q[1] : 32'd0;
		out_w.rms_z          = (2 < ssv_pkg::AXES) ? rms_q[2] : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ax_q           <= '0;
			mul_cnt_q      <= '0;
			timeout_q      <= ssv_pkg::TIMEOUT_RST;
			stale_q        <= ssv_pkg::STALE_RST;
			window_q       <= ssv_pkg::WINDOW_RST;
			err_limit_q    <= ssv_pkg::ERR_LIMIT_RST;
			has_data_q     <= 1'b0;
			last_time_q    <= '0;
			sample_count_q <= '0;
			last_errors_q  <= '0;
			density_q      <= '0;
			equal_run_q    <= '0;
			priority_q     <= '0;
			mask_q         <= '0;
			conf_q         <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i]    <= '0;
				lowpass_q[i] <= '0;
				mean_q[i]    <= '0;
				m2_q[i]      <= '0;
				rms_q[i]     <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					ssv_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data;
					ssv_pkg::REG_STALE:     stale_q     <= cfg_data[15:0];
					ssv_pkg::REG_WINDOW:    window_q    <= cfg_data[15:0];
					ssv_pkg::REG_ERR_LIMIT: err_limit_q <= cfg_data;
					default: ;
				endcase
			end

			// A new result may replace one that transfers in the same cycle.
			priority if (state_q == ST_OUT && out_free_w) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= (item.kind == ssv_pkg::KIND_QUERY) ? ST_Q0 : ST_S0;
					end
				end
				ST_S0: begin
					if (sample_count_q != 32'hFFFF_FFFF) begin
						sample_count_q <= sample_count_q + 32'd1;
					end
					density_q     <= dens_new_w;
					last_errors_q <= item_q.sensor_errors;
					priority_q    <= item_q.sensor_priority;
					conf_q        <= '0;
					ax_q          <= '0;
					if (!has_data_q) begin
						for (int i = 0; i < ssv_pkg::AXES; i++) begin
							mean_q[i]    <= '0;
							m2_q[i]      <= '0;
							lowpass_q[i] <= item_v[i];
							prev_q[i]    <= item_v[i];
						end
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_AX0;
					end
				end
				ST_AX0: begin
					state_q <= ST_DIVM;
				end
				ST_DIVM: begin
					if (div_sts.done) begin
						mean_q[ax_q] <= mean_sat_w;
						state_q      <= ST_MUL;
						mul_cnt_q    <= '0;
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 6'd1;
					if (mul_cnt_q == 6'(MUL_BITS - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					m2_q[ax_q] <= m2_new_w;
					state_q    <= ST_DIVR;
				end
				ST_DIVR: begin
					if (div_sts.done) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (sq_sts.done) begin
						rms_q[ax_q] <= sq_root;
						state_q     <= ST_AXEND;
					end
				end
				ST_AXEND: begin
					// Any unequal axis clears the run before the next axis is checked.
					if (cur_prev == cur_v) begin
						if (equal_run_q != 32'hFFFF_FFFF) begin
							equal_run_q <= equal_run_q + 32'd1;
						end
					end else begin
						equal_run_q <= '0;
					end
					lowpass_q[ax_q] <= lp_sum_w[47:16];
					prev_q[ax_q]    <= cur_v;
					if (ax_q == 2'(ssv_pkg::AXES - 1)) begin
						state_q <= ST_FIN;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_AX0;
					end
				end
				ST_FIN: begin
					has_data_q  <= 1'b1;
					last_time_q <= item_q.time_us;
					state_q     <= ST_OUT;
				end
				ST_Q0: begin
					conf_q <= '0;
					priority if (!has_data_q) begin
						mask_q[ssv_pkg::FLAG_NO_DATA] <= 1'b1;
					end else if (timed_out_w) begin
						mask_q[ssv_pkg::FLAG_TIMEOUT] <= 1'b1;
					end else if (stale_w) begin
						mask_q[ssv_pkg::FLAG_STALE] <= 1'b1;
					end else if (err_over_w) begin
						mask_q[ssv_pkg::FLAG_ERRORS] <= 1'b1;
					end else if (density_q > win_w) begin
						mask_q[ssv_pkg::FLAG_DENSITY] <= 1'b1;
						density_q <= win_w;
					end
					state_q <= q_crit_w ? ST_OUT : ST_QDIV;
				end
				ST_QDIV: begin
					if (div_sts.done) begin
						conf_q <= conf_w[15:0];
						if (conf_w != 17'd0) begin
							mask_q <= '0;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free_w) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers and the serial multiplier datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			item_q <= item;
		end
		if (state_q == ST_OUT && out_free_w) begin
			result_q <= out_w;
		end
		if (state_q == ST_AX0) begin
			d_q      <= d_w;
			delta_q  <= delta_w;
			lp_mul_q <= lp_mul_w;
		end
		if (state_q == ST_DIVM && div_sts.done) begin
			a_q   <= delta_q[34] ? 35'(-delta_q) : 35'(delta_q);
			b_q   <= b_mag_w;
			acc_q <= '0;
		end else if (state_q == ST_MUL) begin
			// Shift-add, most significant multiplier bit first.
			acc_q <= {acc_q[70:0], 1'b0} + (b_q[MUL_BITS-1] ? {37'b0, a_q} : 72'd0);
			b_q   <= {b_q[MUL_BITS-2:0], 1'b0};
		end
	end

	`ASSERT_IMPLIES(a_div_start_idle, clk, arst_n, div_start, !div_sts.busy, "divider restarted while busy")
	`ASSERT_IMPLIES(a_sqrt_start_idle, clk, arst_n, sq_start, !sq_sts.busy, "sqrt restarted while busy")
	`ASSERT_NEXT(a_result_load, clk, arst_n, (state_q == ST_OUT) && out_free_w, result_valid && (state_q == ST_IDLE), "result transfer not loaded")
endmodule
`default_nettype wire
